### src/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

  // Largest supported list; sizes the position fields shared with the cells.
  localparam int MAX_DEPTH     = 1024;
  localparam int CTL_W         = $clog2(MAX_DEPTH + 1);
  localparam int DEF_DEPTH     = 64;
  localparam int DEF_ELEM_W    = 32;

  localparam int ACTION_W      = 3;
  localparam int INDEX_W       = 6;
  localparam int WORD_W        = 32;
  localparam int COUNT_OUT_W   = 7;
  localparam int STATUS_W      = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET    = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_GET    = 3'd3,
    ACT_POP    = 3'd4,
    ACT_REMOVE = 3'd5
  } ils_action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } ils_status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_REMOVE
  } ils_cell_op_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  index;
    logic [WORD_W-1:0]   value;
  } ils_in_t;

  typedef struct packed {
    logic [WORD_W-1:0]      value_out;
    logic [COUNT_OUT_W-1:0] count;
    logic [STATUS_W-1:0]    status;
  } ils_out_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    ils_cell_op_t     op;
    logic [CTL_W-1:0] pos;
    logic [CTL_W-1:0] cnt;
    logic [CTL_W-1:0] rd_pos;
  } ils_cell_ctrl_t;

endpackage

### src/indexed_list_store.sv
`timescale 1ns / 1ps
// A request accepted at one clock edge has its result on out_res,
// strobed by out_valid, in the cycle after that edge.
// Throughput: one request per cycle; every cell of the row updates in the same
// cycle, so busy stays low and the receiver cannot stall the result.
// Reset (rst_n low, synchronous): count cleared to zero, no result pending.
// Entry contents are not reset; only entries below the count are ever read.
module indexed_list_store #(
  parameter int DEPTH         = ils_pkg::DEF_DEPTH,
  parameter int ELEMENT_WIDTH = ils_pkg::DEF_ELEM_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ils_pkg::ils_in_t  in_req,
  output logic              out_valid,
  output ils_pkg::ils_out_t out_res
);
  import ils_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // live entry count
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;

  // result register
  logic                     out_valid_r;
  ils_out_t                 out_res_r;

  logic                     accept;
  ils_cell_ctrl_t           cell_ctrl;
  ils_status_t              status;
  logic                     rd_en;
  logic [ELEMENT_WIDTH-1:0] wr_data;

  // cell contents and their gated read words
  logic [DEPTH-1:0][ELEMENT_WIDTH-1:0] cell_q;
  logic [DEPTH-1:0][ELEMENT_WIDTH-1:0] cell_rd;
  logic [ELEMENT_WIDTH-1:0]            rd_any;

  // Every request completes in the cycle it is taken.
  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  // Mask or widen the request word to the element width.
  assign wr_data = ELEMENT_WIDTH'(in_req.value);

  // Decode the request against the current count into one broadcast control word.
  ils_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .cmd_valid_i (accept),
    .req_i       (in_req),
    .count_i     (count_r),
    .ctrl_o      (cell_ctrl),
    .count_nxt_o (count_nxt),
    .status_o    (status),
    .rd_en_o     (rd_en)
  );

  // Row of cells: cell i holds entry i, takes from i-1 on insert, from i+1 on
  // remove. The ends of the row see zero from beyond.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] left_w;
    logic [ELEMENT_WIDTH-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end

    ils_cell #(
      .INDEX         (i),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl_i    (cell_ctrl),
      .wr_data_i (wr_data),
      .left_i    (left_w),
      .right_i   (right_w),
      .data_o    (cell_q[i]),
      .rd_o      (cell_rd[i])
    );
  end

  // Only the addressed cell drives a nonzero read word; OR them together.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  // Advance the count and register the result; refused requests read zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r.value_out <= rd_en ? WORD_W'(rd_any) : '0;
      out_res_r.count     <= COUNT_OUT_W'(count_nxt);
      out_res_r.status    <= status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### src/ils_cell.sv
`timescale 1ns / 1ps

module ils_cell #(
  parameter int INDEX         = 0,
  parameter int ELEMENT_WIDTH = ils_pkg::DEF_ELEM_W
) (
  input  logic                       clk,
  input  ils_pkg::ils_cell_ctrl_t    ctrl_i,
  input  logic [ELEMENT_WIDTH-1:0]   wr_data_i,
  input  logic [ELEMENT_WIDTH-1:0]   left_i,
  input  logic [ELEMENT_WIDTH-1:0]   right_i,
  output logic [ELEMENT_WIDTH-1:0]   data_o,
  output logic [ELEMENT_WIDTH-1:0]   rd_o
);
  import ils_pkg::*;

  localparam logic [CTL_W-1:0] MyPos  = CTL_W'(INDEX);
  localparam logic [CTL_W-1:0] MyNext = CTL_W'(INDEX + 1);

  logic [ELEMENT_WIDTH-1:0] data_r;
  logic [ELEMENT_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctrl_i.op)
      CELL_HOLD: data_nxt = data_r;
      CELL_WRITE: begin
        if (ctrl_i.pos == MyPos) data_nxt = wr_data_i;
      end
      CELL_INSERT: begin
        // open the gap: the addressed cell takes the new word, those above shift up
        if (ctrl_i.pos == MyPos) begin
          data_nxt = wr_data_i;
        end else if ((MyPos > ctrl_i.pos) && (MyPos <= ctrl_i.cnt)) begin
          data_nxt = left_i;
        end
      end
      CELL_REMOVE: begin
        // close the gap: pull down from the neighbor above
        if ((MyPos >= ctrl_i.pos) && (MyNext < ctrl_i.cnt)) data_nxt = right_i;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = (ctrl_i.rd_pos == MyPos) ? data_r : '0;

endmodule

### src/ils_ctrl.sv
`timescale 1ns / 1ps

module ils_ctrl #(
  parameter int DEPTH = ils_pkg::DEF_DEPTH
) (
  input  logic                          cmd_valid_i,
  input  ils_pkg::ils_in_t              req_i,
  input  logic [$clog2(DEPTH+1)-1:0]    count_i,
  output ils_pkg::ils_cell_ctrl_t       ctrl_o,
  output logic [$clog2(DEPTH+1)-1:0]    count_nxt_o,
  output ils_pkg::ils_status_t          status_o,
  output logic                          rd_en_o
);
  import ils_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CTL_W-1:0] DepthW = CTL_W'(DEPTH);

  logic [CTL_W-1:0] cnt_w;
  logic [CTL_W-1:0] idx_w;
  logic [CTL_W-1:0] last_w;
  logic             full;
  logic             empty;

  assign cnt_w  = CTL_W'(count_i);
  assign idx_w  = CTL_W'(req_i.index);
  assign last_w = cnt_w - CTL_W'(1);
  assign full   = (cnt_w == DepthW);
  assign empty  = (cnt_w == '0);

  always_comb begin
    ctrl_o.op     = CELL_HOLD;
    ctrl_o.pos    = idx_w;
    ctrl_o.cnt    = cnt_w;
    ctrl_o.rd_pos = idx_w;
    count_nxt_o   = count_i;
    status_o      = ST_OK;
    rd_en_o       = 1'b0;
    if (cmd_valid_i) begin
      unique case (req_i.action)
        ACT_SET: begin
          if (idx_w >= cnt_w) begin
            // clamped to the end: behaves as append
            if (full) begin
              status_o = ST_FULL;
            end else begin
              ctrl_o.op   = CELL_WRITE;
              ctrl_o.pos  = cnt_w;
              count_nxt_o = CW'(cnt_w + CTL_W'(1));
            end
          end else begin
            ctrl_o.op = CELL_WRITE;
          end
        end
        ACT_APPEND: begin
          if (full) begin
            status_o = ST_FULL;
          end else begin
            ctrl_o.op   = CELL_WRITE;
            ctrl_o.pos  = cnt_w;
            count_nxt_o = CW'(cnt_w + CTL_W'(1));
          end
        end
        ACT_INSERT: begin
          if (full) begin
            status_o = ST_FULL;
          end else if (idx_w > cnt_w) begin
            status_o = ST_RANGE;
          end else begin
            ctrl_o.op   = CELL_INSERT;
            count_nxt_o = CW'(cnt_w + CTL_W'(1));
          end
        end
        ACT_GET: begin
          if (empty) begin
            status_o = ST_EMPTY;
          end else begin
            rd_en_o       = 1'b1;
            ctrl_o.rd_pos = (idx_w >= cnt_w) ? last_w : idx_w;
          end
        end
        ACT_POP: begin
          if (empty) begin
            status_o = ST_EMPTY;
          end else begin
            rd_en_o       = 1'b1;
            ctrl_o.rd_pos = last_w;
            count_nxt_o   = CW'(last_w);
          end
        end
        ACT_REMOVE: begin
          if (empty) begin
            status_o = ST_EMPTY;
          end else if (idx_w >= cnt_w) begin
            status_o = ST_RANGE;
          end else begin
            rd_en_o     = 1'b1;
            ctrl_o.op   = CELL_REMOVE;
            count_nxt_o = CW'(last_w);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### src/ils_checker.sv
`timescale 1ns / 1ps

module ils_port_checker #(
  parameter int DEPTH = ils_pkg::DEF_DEPTH
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input ils_pkg::ils_in_t  in_req,
  input logic              out_valid,
  input ils_pkg::ils_out_t out_res
);
  import ils_pkg::*;

  // Exactly one result, in the cycle after each accepted request.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted request gave no result");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without a request");

  // A full refusal only happens at capacity, an empty one only at zero.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status == ST_FULL) |-> out_res.count == COUNT_OUT_W'(DEPTH))
    else $error("full refusal below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status == ST_EMPTY) |-> out_res.count == '0)
    else $error("empty refusal with live entries");

  // Write requests never return data.
  a_write_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_req.action) == ACT_SET || $past(in_req.action) == ACT_APPEND
                   || $past(in_req.action) == ACT_INSERT)) |-> out_res.value_out == '0)
    else $error("write request returned data");

endmodule

bind indexed_list_store ils_port_checker #(.DEPTH(DEPTH)) u_ils_checker (.*);
